>>> rtl/cce_pkg.sv
// Shared types, constants and bit helpers for the configurable CRC engine.
`default_nettype none

package cce_pkg;

  typedef enum logic [1:0] {
    WIDTH_7  = 2'd0,
    WIDTH_8  = 2'd1,
    WIDTH_16 = 2'd2,
    WIDTH_32 = 2'd3
  } width_t;

  typedef enum logic [2:0] {
    REG_WIDTH_SELECT   = 3'd0,
    REG_POLYNOMIAL     = 3'd1,
    REG_INITIAL_VALUE  = 3'd2,
    REG_REFLECT_INPUT  = 3'd3,
    REG_REFLECT_OUTPUT = 3'd4,
    REG_FINAL_XOR      = 3'd5
  } reg_index_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam width_t      RESET_WIDTH_SELECT   = WIDTH_32;
  localparam logic [31:0] RESET_POLYNOMIAL     = 32'h04C1_1DB7;
  localparam logic [31:0] RESET_INITIAL_VALUE  = 32'hFFFF_FFFF;
  localparam logic        RESET_REFLECT_INPUT  = 1'b1;
  localparam logic        RESET_REFLECT_OUTPUT = 1'b1;
  localparam logic [31:0] RESET_FINAL_XOR      = 32'hFFFF_FFFF;

  typedef struct packed {
    width_t      width_select;
    logic [31:0] polynomial;
    logic [31:0] initial_value;
    logic        reflect_input;
    logic        reflect_output;
    logic [31:0] final_xor;
  } cfg_t;

  // One classified message item as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       absorb;
    logic       load;
    logic       emit;
  } op_t;

  function automatic logic [31:0] width_mask(input width_t w);
    logic [31:0] m;
    unique case (w)
      WIDTH_7:  m = 32'h0000_007F;
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] reverse32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  // Bit reversal over the low bits of the selected width.
  function automatic logic [31:0] reflect_width(input logic [31:0] v, input width_t w);
    logic [31:0] r;
    logic [31:0] res;
    r = reverse32(v);
    unique case (w)
      WIDTH_7:  res = r >> 25;
      WIDTH_8:  res = r >> 24;
      WIDTH_16: res = r >> 16;
      default:  res = r;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cce_front.sv
// Input stage: takes message items and classifies them into queue operations.
`default_nettype none

module cce_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [7:0]        data_byte,
  input  wire               carries_byte,
  input  wire               first_item,
  input  wire               last_item,
  input  wire               q_full,
  output logic              push,
  output cce_pkg::op_t      push_op
);

  logic         valid;
  cce_pkg::op_t op;

  assign in_stall = valid && q_full;
  assign push     = valid && !q_full;
  assign push_op  = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op.data_byte <= data_byte;
      op.absorb    <= carries_byte;
      op.load      <= first_item;
      op.emit      <= last_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cce_queue.sv
// Short queue of classified operations between the front and the back.
`default_nettype none

module cce_queue #(
  parameter int unsigned DEPTH = cce_pkg::QUEUE_DEPTH
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  cce_pkg::op_t  push_op,
  output logic          full,
  input  wire           pop,
  output cce_pkg::op_t  pop_op,
  output logic          not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cce_pkg::op_t     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/cce_back.sv
// Execution stage: running remainder, byte update, finishing and result register.
`default_nettype none

module cce_back (
  input  wire           clk,
  input  wire           rst,
  input  cce_pkg::cfg_t cfg,
  input  wire           q_not_empty,
  input  cce_pkg::op_t  q_op,
  output logic          pop,
  output logic          out_valid,
  input  wire           out_stall,
  output logic [31:0]   crc_result
);

  logic [31:0] remainder;
  logic [31:0] remainder_next;
  logic [31:0] result_next;
  logic [31:0] mask;
  logic        is7;
  logic [4:0]  align;
  logic [31:0] start;
  logic [31:0] c;
  logic [31:0] p;
  logic [31:0] absorbed;
  logic [31:0] fin;

  // An item that ends a message needs room in the result register.
  assign pop = q_not_empty && (!q_op.emit || !out_valid || !out_stall);

  always_comb begin
    mask = cce_pkg::width_mask(cfg.width_select);
    is7  = (cfg.width_select == cce_pkg::WIDTH_7);
    unique case (cfg.width_select)
      cce_pkg::WIDTH_7:  align = 5'd24;
      cce_pkg::WIDTH_8:  align = 5'd24;
      cce_pkg::WIDTH_16: align = 5'd16;
      default:           align = 5'd0;
    endcase

    if (q_op.load) begin
      start = is7 ? {24'b0, cfg.initial_value[6:0], 1'b0} : (cfg.initial_value & mask);
    end else begin
      start = remainder;
    end

    if (is7 || !cfg.reflect_input) begin
      // MSB-first: the register is left-aligned so one loop serves every width.
      // CRC-7 runs as an 8-bit register with the polynomial moved up one place.
      c = is7 ? (start & 32'h0000_00FF) : (start & mask);
      p = is7 ? {24'b0, cfg.polynomial[6:0], 1'b0} : (cfg.polynomial & mask);
      c = (c << align) ^ {q_op.data_byte, 24'b0};
      p = p << align;
      for (int k = 0; k < 8; k++) begin
        c = c[31] ? ((c << 1) ^ p) : (c << 1);
      end
      absorbed = c >> align;
    end else begin
      c = (start & mask) ^ {24'b0, q_op.data_byte};
      p = cce_pkg::reflect_width(cfg.polynomial & mask, cfg.width_select);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
      end
      absorbed = c & mask;
    end

    remainder_next = q_op.absorb ? absorbed : start;

    fin = is7 ? {25'b0, remainder_next[7:1]} : (remainder_next & mask);
    if (cfg.reflect_input != cfg.reflect_output) begin
      fin = cce_pkg::reflect_width(fin, cfg.width_select);
    end
    result_next = (fin ^ cfg.final_xor) & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        remainder <= remainder_next;
      end
      if (pop && q_op.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_op.emit) begin
      crc_result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/configurable_crc_engine.sv
// A result is registered after the item that ends its message passes the input register and the queue.
// Throughput: one byte per cycle while nothing stalls; the eight-step remainder update is combinational.
// With the result stalled, input runs on until the item ending a message blocks the queue and it fills.
// Reset clears the remainder to zero, empties the pipeline and loads the CRC-32 settings.
// Configuration registers take effect for items processed after the write.
`default_nettype none

module configurable_crc_engine #(
  parameter int unsigned QUEUE_DEPTH = cce_pkg::QUEUE_DEPTH
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_write_enable,
  input  wire  [cce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [cce_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [7:0]                      data_byte,
  input  wire                             carries_byte,
  input  wire                             first_item,
  input  wire                             last_item,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [31:0]                     crc_result
);

  cce_pkg::cfg_t cfg;
  cce_pkg::op_t  push_op;
  cce_pkg::op_t  q_op;
  logic          push;
  logic          q_full;
  logic          pop;
  logic          q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_select   <= cce_pkg::RESET_WIDTH_SELECT;
      cfg.polynomial     <= cce_pkg::RESET_POLYNOMIAL;
      cfg.initial_value  <= cce_pkg::RESET_INITIAL_VALUE;
      cfg.reflect_input  <= cce_pkg::RESET_REFLECT_INPUT;
      cfg.reflect_output <= cce_pkg::RESET_REFLECT_OUTPUT;
      cfg.final_xor      <= cce_pkg::RESET_FINAL_XOR;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        cce_pkg::REG_WIDTH_SELECT:   cfg.width_select   <= cce_pkg::width_t'(cfg_data[1:0]);
        cce_pkg::REG_POLYNOMIAL:     cfg.polynomial     <= cfg_data;
        cce_pkg::REG_INITIAL_VALUE:  cfg.initial_value  <= cfg_data;
        cce_pkg::REG_REFLECT_INPUT:  cfg.reflect_input  <= cfg_data[0];
        cce_pkg::REG_REFLECT_OUTPUT: cfg.reflect_output <= cfg_data[0];
        cce_pkg::REG_FINAL_XOR:      cfg.final_xor      <= cfg_data;
        default: ;
      endcase
    end
  end

  cce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .carries_byte (carries_byte),
    .first_item   (first_item),
    .last_item    (last_item),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  cce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .pop_op    (q_op),
    .not_empty (q_not_empty)
  );

  cce_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_op        (q_op),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .crc_result  (crc_result)
  );

endmodule

`default_nettype wire

>>> rtl/cce_checker.sv
// Port-level checks of the CRC engine and the bind that attaches them.
`default_nettype none

module cce_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] crc_result
);

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("output valid or input stall after reset");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(crc_result)))
    else $error("stalled result changed or dropped");

  // A result only leaves through a transfer.
  a_result_leaves: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without a transfer");

  // Backpressure on the input starts only after an item was taken in.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall without a preceding transfer");

endmodule

bind configurable_crc_engine cce_checker u_cce_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .crc_result (crc_result)
);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the configurable CRC engine: directed table, then random messages.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cce_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam logic [31:0] BYTE_FIELD   = 32'h0000_00FF;
  localparam logic [31:0] CRC7_FIELD   = 32'h0000_007F;
  localparam logic [31:0] CRC32_CHECK  = 32'hCBF4_3926;

  typedef struct {
    bit          is_cfg;
    reg_index_t  idx;
    logic [31:0] value;    // register value, or the typed-in CRC when known is set
    logic [7:0]  b;
    bit          has_byte;
    bit          is_first;
    bit          is_last;
    bit          known;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        carries_byte = 1'b0;
  logic        first_item = 1'b0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] crc_result;

  // Mirror of the engine: configuration and running remainder.
  width_t      cfg_width;
  logic [31:0] cfg_poly;
  logic [31:0] cfg_init;
  bit          cfg_refl_in;
  bit          cfg_refl_out;
  logic [31:0] cfg_xorout;
  logic [31:0] remainder;

  logic [31:0] crc_due[$];
  stim_row_t   plan[$];
  int unsigned failures = 0;
  int unsigned sent = 0;
  int unsigned hold = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  logic [31:0] want;

  configurable_crc_engine i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .carries_byte     (carries_byte),
    .first_item       (first_item),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .crc_result       (crc_result)
  );

  always #5 clk = ~clk;

  function automatic int unsigned bits_of(width_t w);
    case (w)
      WIDTH_7:  return 7;
      WIDTH_8:  return 8;
      WIDTH_16: return 16;
      default:  return 32;
    endcase
  endfunction

  function automatic logic [31:0] low_mask(int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function automatic logic [31:0] mirror(logic [31:0] v, int unsigned n);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < int'(n); i++) begin
      r[int'(n) - 1 - i] = v[i];
    end
    return r;
  endfunction

  // Advances the remainder by one item; returns 1 with the finished CRC when the item ends a message.
  function automatic bit crc_step(logic [7:0] b, bit has_byte, bit is_first, bit is_last,
                                  output logic [31:0] crc);
    int unsigned n;
    logic [31:0] m;
    logic [31:0] p;
    logic [31:0] c;
    n = bits_of(cfg_width);
    m = low_mask(n);
    crc = '0;
    if (is_first) begin
      remainder = (n == 7) ? {24'd0, cfg_init[6:0], 1'b0} : (cfg_init & m);
    end
    if (has_byte) begin
      c = remainder;
      if (n == 7) begin
        // CRC-7 runs MSB-first in an 8-bit register with everything shifted up one place.
        p = {24'd0, cfg_poly[6:0], 1'b0};
        c = (c ^ {24'd0, b}) & BYTE_FIELD;
        for (int k = 0; k < 8; k++) begin
          c = c[7] ? (((c << 1) ^ p) & BYTE_FIELD) : ((c << 1) & BYTE_FIELD);
        end
      end else if (cfg_refl_in) begin
        p = mirror(cfg_poly & m, n);
        c = (c & m) ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
          c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
        end
        c = c & m;
      end else begin
        p = cfg_poly & m;
        c = (c & m) ^ ({24'd0, b} << (n - 8));
        for (int k = 0; k < 8; k++) begin
          c = c[n - 1] ? (((c << 1) ^ p) & m) : ((c << 1) & m);
        end
      end
      remainder = c;
    end
    if (is_last) begin
      c = (n == 7) ? ((remainder >> 1) & CRC7_FIELD) : (remainder & m);
      if (cfg_refl_in != cfg_refl_out) begin
        c = mirror(c, n);
      end
      crc = (c ^ cfg_xorout) & m;
    end
    return is_last;
  endfunction

  function automatic void add_item(logic [7:0] b, bit has_byte, bit is_first, bit is_last,
                                   bit known, logic [31:0] crc);
    stim_row_t row;
    row = '{is_cfg: 1'b0, idx: REG_WIDTH_SELECT, value: crc, b: b, has_byte: has_byte,
            is_first: is_first, is_last: is_last, known: known};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(reg_index_t idx, logic [31:0] value);
    stim_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, value: value, b: 8'h00, has_byte: 1'b0,
            is_first: 1'b0, is_last: 1'b0, known: 1'b0};
    plan.push_back(row);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_item(logic [7:0] b, bit has_byte, bit is_first, bit is_last,
                           bit known, logic [31:0] known_crc);
    int unsigned gap;
    logic [31:0] crc;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 31) == 0) begin
      in_calm = !in_calm;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    carries_byte <= has_byte;
    first_item   <= is_first;
    last_item    <= is_last;
    do @(posedge clk); while (in_stall);
    sent++;
    if (crc_step(b, has_byte, is_first, is_last, crc)) begin
      crc_due.push_back(known ? known_crc : crc);
    end
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WIDTH_SELECT:   cfg_width = width_t'(value[1:0]);
      REG_POLYNOMIAL:     cfg_poly = value;
      REG_INITIAL_VALUE:  cfg_init = value;
      REG_REFLECT_INPUT:  cfg_refl_in = value[0];
      REG_REFLECT_OUTPUT: cfg_refl_out = value[0];
      REG_FINAL_XOR:      cfg_xorout = value;
      default: ;
    endcase
  endtask

  // Waits until every expected CRC has arrived and items that emit nothing have left the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (crc_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_message();
    int unsigned len;
    bit opens;
    bit closes;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    // Occasionally leave the start or the end off so messages run across each other.
    opens  = $urandom_range(0, 15) != 0;
    closes = $urandom_range(0, 15) != 0;
    if (len == 0) begin
      send_item(8'($urandom), 1'b0, opens, closes, 1'b0, '0);
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        send_item(8'($urandom), $urandom_range(0, 15) != 0, opens && i == 0,
                  closes && i == len - 1, 1'b0, '0);
      end
    end
  endtask

  // Result side: check each transfer, then hold off for a random number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (crc_due.size() == 0) begin
          $display("%0t ns: crc_result expected none, got %h", $time, crc_result);
          failures++;
        end else begin
          want = crc_due.pop_front();
          if (crc_result !== want) begin
            $display("%0t ns: crc_result expected %h, got %h", $time, want, crc_result);
            failures++;
          end
        end
        hold = out_calm ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 31) == 0) begin
          out_calm = !out_calm;
        end
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned phase_end;
    cfg_width    = WIDTH_32;
    cfg_poly     = 32'h04C1_1DB7;
    cfg_init     = 32'hFFFF_FFFF;
    cfg_refl_in  = 1'b1;
    cfg_refl_out = 1'b1;
    cfg_xorout   = 32'hFFFF_FFFF;
    remainder    = '0;

    // A byte ahead of any message start folds into the cleared remainder.
    add_item(8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_item(8'h5A, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
    for (int d = 1; d <= 9; d++) begin
      add_item(8'h30 + 8'(d), 1'b1, d == 1, d == 9, 1'b1, CRC32_CHECK);
    end
    add_item(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, '0);
    add_item(8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, '0);
    add_item(8'h80, 1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_item(8'h01, 1'b1, 1'b0, 1'b1, 1'b0, '0);
    add_cfg(REG_WIDTH_SELECT, 32'(WIDTH_7));
    add_cfg(REG_POLYNOMIAL, 32'h0000_0009);
    add_cfg(REG_INITIAL_VALUE, 32'h0000_0000);
    add_cfg(REG_REFLECT_INPUT, 32'h0000_0000);
    add_cfg(REG_REFLECT_OUTPUT, 32'h0000_0000);
    add_cfg(REG_FINAL_XOR, 32'h0000_0000);
    add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
    add_cfg(REG_FINAL_XOR, 32'hFFFF_FFFF);
    add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_007F);
    add_item(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, '0);
    add_cfg(REG_WIDTH_SELECT, 32'(WIDTH_16));
    add_cfg(REG_POLYNOMIAL, 32'hFFFF_FFFF);
    add_cfg(REG_INITIAL_VALUE, 32'hFFFF_FFFF);
    add_cfg(REG_REFLECT_OUTPUT, 32'h0000_0001);
    add_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, '0);
    add_item(8'h00, 1'b1, 1'b0, 1'b1, 1'b0, '0);
    add_cfg(REG_WIDTH_SELECT, 32'(WIDTH_8));
    add_cfg(REG_POLYNOMIAL, 32'h0000_0000);
    add_cfg(REG_INITIAL_VALUE, 32'h0000_0000);
    add_cfg(REG_REFLECT_INPUT, 32'h0000_0001);
    add_cfg(REG_REFLECT_OUTPUT, 32'h0000_0000);
    add_cfg(REG_FINAL_XOR, 32'h0000_0000);
    add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_0000);
    add_item(8'hC3, 1'b1, 1'b1, 1'b1, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_item(plan[i].b, plan[i].has_byte, plan[i].is_first, plan[i].is_last,
                  plan[i].known, plan[i].value);
      end
    end

    // Random phases: a fresh mix of register values, then a run of messages and noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      for (int r = 0; r <= int'(REG_FINAL_XOR); r++) begin
        if ($urandom_range(0, 3) != 0) begin
          write_reg(reg_index_t'(r), pick_word());
        end
      end
      phase_end = sent + $urandom_range(20, 90);
      while (sent < phase_end) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, '0);
          end
        end else begin
          send_message();
        end
      end
    end

    settle();
    if (failures == 0) begin
      $display("PASS configurable_crc_engine");
    end else begin
      $display("FAIL configurable_crc_engine");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL configurable_crc_engine");
    $finish;
  end

endmodule
